@@ design/countdown_timer_with_joystick_edit_macros.svh @@
// Assertion helpers for the countdown timer.
`ifndef COUNTDOWN_TIMER_WITH_JOYSTICK_EDIT_MACROS_SVH
`define COUNTDOWN_TIMER_WITH_JOYSTICK_EDIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CTJE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctje: same-cycle check failed");
// next-cycle implication
`define CTJE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctje: next-cycle check failed");
`else
`define CTJE_ASSERT_IMP(label, clk, rst, ante, cons)
`define CTJE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ design/ctje_pkg.sv @@
package ctje_pkg;

  localparam int AXIS_W = 7;
  localparam int CNT_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_HOLDOFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_PERIOD    = 3'd4;

  // register reset values
  localparam logic [AXIS_W-1:0] HIGH_THRESHOLD_RST = 7'd75;
  localparam logic [AXIS_W-1:0] LOW_THRESHOLD_RST  = 7'd25;
  localparam logic [CNT_W-1:0]  SWIPE_HOLDOFF_RST  = 16'd500;
  localparam logic [CNT_W-1:0]  CURSOR_PERIOD_RST  = 16'd250;
  localparam logic [CNT_W-1:0]  COUNT_PERIOD_RST   = 16'd1000;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // cursor positions
  localparam logic [3:0] CUR_START     = 4'd1;
  localparam logic [3:0] CUR_HOUR_TENS = 4'd7;
  localparam logic [3:0] CUR_HOUR_ONES = 4'd8;
  localparam logic [3:0] CUR_MIN_TENS  = 4'd10;
  localparam logic [3:0] CUR_MIN_ONES  = 4'd11;
  localparam logic [3:0] CUR_SEC_TENS  = 4'd13;
  localparam logic [3:0] CUR_SEC_ONES  = 4'd14;
  localparam logic [3:0] CUR_RST       = CUR_SEC_ONES;

  localparam int NUM_POS = 7;
  localparam logic [3:0] POSITIONS [NUM_POS] = '{
    CUR_START, CUR_HOUR_TENS, CUR_HOUR_ONES, CUR_MIN_TENS,
    CUR_MIN_ONES, CUR_SEC_TENS, CUR_SEC_ONES
  };

  localparam logic [6:0] HOUR_MAX = 7'd99;
  localparam logic [5:0] MS_MAX   = 6'd59;

  typedef struct packed {
    logic [AXIS_W-1:0] axis_x;
    logic [AXIS_W-1:0] axis_y;
  } sample_t;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [3:0] cursor;
    logic       armed;
    logic       running;
    logic       alarm;
  } result_t;

  typedef struct packed {
    logic [AXIS_W-1:0] high_threshold;
    logic [AXIS_W-1:0] low_threshold;
    logic [CNT_W-1:0]  swipe_holdoff_ticks;
    logic [CNT_W-1:0]  cursor_period_ticks;
    logic [CNT_W-1:0]  count_period_ticks;
  } cfg_t;

  // next listed position above cur, else cur
  function automatic logic [3:0] step_right(input logic [3:0] cur);
    logic [3:0] r;
    r = cur;
    for (int i = NUM_POS - 1; i >= 0; i--) begin
      if (POSITIONS[i] > cur) r = POSITIONS[i];
    end
    return r;
  endfunction

  // next listed position below cur, else cur
  function automatic logic [3:0] step_left(input logic [3:0] cur);
    logic [3:0] r;
    r = cur;
    for (int i = 0; i < NUM_POS; i++) begin
      if (POSITIONS[i] < cur) r = POSITIONS[i];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

@@ design/ctje_cfg.sv @@
module ctje_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ctje_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctje_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ctje_pkg::cfg_t                     cfg
);
  import ctje_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold      <= HIGH_THRESHOLD_RST;
      cfg.low_threshold       <= LOW_THRESHOLD_RST;
      cfg.swipe_holdoff_ticks <= SWIPE_HOLDOFF_RST;
      cfg.cursor_period_ticks <= CURSOR_PERIOD_RST;
      cfg.count_period_ticks  <= COUNT_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_THRESHOLD: cfg.high_threshold      <= cfg_data[AXIS_W-1:0];
        REG_LOW_THRESHOLD:  cfg.low_threshold       <= cfg_data[AXIS_W-1:0];
        REG_SWIPE_HOLDOFF:  cfg.swipe_holdoff_ticks <= cfg_data[CNT_W-1:0];
        REG_CURSOR_PERIOD:  cfg.cursor_period_ticks <= cfg_data[CNT_W-1:0];
        REG_COUNT_PERIOD:   cfg.count_period_ticks  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/ctje_core.sv @@
`include "countdown_timer_with_joystick_edit_macros.svh"

module ctje_core (
  input  logic                clk,
  input  logic                rst,
  input  ctje_pkg::cfg_t      cfg,
  input  logic                advance,
  input  ctje_pkg::sample_t   sample,
  output ctje_pkg::result_t   res
);
  import ctje_pkg::*;

  logic [6:0]       hour_count, hour_count_next;
  logic [5:0]       minute_count, minute_count_next;
  logic [5:0]       second_count, second_count_next;
  logic [3:0]       cursor_pos, cursor_pos_next;
  logic             armed_flag, armed_flag_next;
  logic             started_flag, started_flag_next;
  logic [CNT_W-1:0] holdoff_counter, holdoff_counter_next;
  logic [CNT_W-1:0] cursor_counter, cursor_counter_next;
  logic [CNT_W-1:0] period_counter, period_counter_next;

  logic [CNT_W-1:0] hold_b, cur_b, per_b;
  logic             hold_done, cursor_tick, count_tick;
  logic             x_hi, x_lo, y_hi, y_lo;
  logic             swipe_x, swipe_y;
  logic [6:0]       h;
  logic [5:0]       m, s;
  logic             alarm;

  // check terms
  logic             time_legal, cursor_legal, expired_state, swipe_any;

  always_comb begin
    hold_b = bump(holdoff_counter);
    cur_b  = bump(cursor_counter);
    per_b  = bump(period_counter);

    x_hi = sample.axis_x > cfg.high_threshold;
    x_lo = sample.axis_x < cfg.low_threshold;
    y_hi = sample.axis_y > cfg.high_threshold;
    y_lo = sample.axis_y < cfg.low_threshold;

    cursor_tick = cur_b >= cfg.cursor_period_ticks;
    count_tick  = per_b >= cfg.count_period_ticks;
    hold_done   = hold_b >= cfg.swipe_holdoff_ticks;

    // cursor phase; a left/right swipe uses up the holdoff for this tick
    swipe_x = cursor_tick && hold_done && (x_hi || x_lo);
    swipe_y = hold_done && !swipe_x && (y_hi || y_lo);

    cursor_pos_next      = cursor_pos;
    armed_flag_next      = armed_flag;
    started_flag_next    = started_flag;
    holdoff_counter_next = (swipe_x || swipe_y) ? '0 : hold_b;
    cursor_counter_next  = cursor_tick ? '0 : cur_b;
    period_counter_next  = count_tick ? '0 : per_b;

    if (swipe_x) begin
      cursor_pos_next = x_hi ? step_right(cursor_pos) : step_left(cursor_pos);
      armed_flag_next = 1'b0;
    end

    // edit phase
    h = hour_count;
    m = minute_count;
    s = second_count;
    if (swipe_y) begin
      armed_flag_next = y_hi;
      case (cursor_pos_next)
        CUR_HOUR_TENS: begin
          if (y_hi) h = (h > HOUR_MAX - 7'd10) ? HOUR_MAX : h + 7'd10;
          else      h = (h < 7'd10) ? 7'd0 : h - 7'd10;
        end
        CUR_HOUR_ONES: begin
          if (y_hi) h = (h >= HOUR_MAX) ? HOUR_MAX : h + 7'd1;
          else      h = (h == 7'd0) ? 7'd0 : h - 7'd1;
        end
        CUR_MIN_TENS: begin
          if (y_hi) m = (m > MS_MAX - 6'd10) ? MS_MAX : m + 6'd10;
          else      m = (m < 6'd10) ? 6'd0 : m - 6'd10;
        end
        CUR_MIN_ONES: begin
          if (y_hi) m = (m >= MS_MAX) ? MS_MAX : m + 6'd1;
          else      m = (m == 6'd0) ? 6'd0 : m - 6'd1;
        end
        CUR_SEC_TENS: begin
          if (y_hi) s = (s > MS_MAX - 6'd10) ? MS_MAX : s + 6'd10;
          else      s = (s < 6'd10) ? 6'd0 : s - 6'd10;
        end
        CUR_SEC_ONES: begin
          if (y_hi) s = (s >= MS_MAX) ? MS_MAX : s + 6'd1;
          else      s = (s == 6'd0) ? 6'd0 : s - 6'd1;
        end
        default: ;
      endcase
    end

    // count phase: borrow down, alarm at zero once started
    alarm = 1'b0;
    if (count_tick && cursor_pos_next == CUR_START && armed_flag_next) begin
      if (h != '0 || m != '0 || s != '0) begin
        started_flag_next = 1'b1;
        if (s != '0) begin
          s = s - 6'd1;
        end else if (m != '0) begin
          m = m - 6'd1;
          s = MS_MAX;
        end else begin
          h = h - 7'd1;
          m = MS_MAX;
          s = MS_MAX;
        end
      end else if (started_flag) begin
        alarm = 1'b1;
      end
    end

    hour_count_next   = h;
    minute_count_next = m;
    second_count_next = s;

    res.hours   = h;
    res.minutes = m;
    res.seconds = s;
    res.cursor  = cursor_pos_next;
    res.armed   = armed_flag_next;
    res.running = started_flag_next;
    res.alarm   = alarm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count      <= '0;
      minute_count    <= '0;
      second_count    <= '0;
      cursor_pos      <= CUR_RST;
      armed_flag      <= 1'b0;
      started_flag    <= 1'b0;
      holdoff_counter <= '0;
      cursor_counter  <= '0;
      period_counter  <= '0;
    end else if (advance) begin
      hour_count      <= hour_count_next;
      minute_count    <= minute_count_next;
      second_count    <= second_count_next;
      cursor_pos      <= cursor_pos_next;
      armed_flag      <= armed_flag_next;
      started_flag    <= started_flag_next;
      holdoff_counter <= holdoff_counter_next;
      cursor_counter  <= cursor_counter_next;
      period_counter  <= period_counter_next;
    end
  end

  assign time_legal = (hour_count <= HOUR_MAX) && (minute_count <= MS_MAX) &&
                      (second_count <= MS_MAX);
  assign cursor_legal = (cursor_pos == CUR_START) || (cursor_pos == CUR_HOUR_TENS) ||
                        (cursor_pos == CUR_HOUR_ONES) || (cursor_pos == CUR_MIN_TENS) ||
                        (cursor_pos == CUR_MIN_ONES) || (cursor_pos == CUR_SEC_TENS) ||
                        (cursor_pos == CUR_SEC_ONES);
  assign expired_state = (hour_count == '0) && (minute_count == '0) &&
                         (second_count == '0) && started_flag && armed_flag;
  assign swipe_any = swipe_x || swipe_y;

  `CTJE_ASSERT_IMP(a_time_range, clk, rst, 1'b1, time_legal)
  `CTJE_ASSERT_IMP(a_cursor_legal, clk, rst, 1'b1, cursor_legal)
  `CTJE_ASSERT_NEXT(a_alarm_expired, clk, rst, advance && alarm, expired_state)
  `CTJE_ASSERT_NEXT(a_holdoff_restart, clk, rst, advance && swipe_any, holdoff_counter == '0)

endmodule

@@ design/countdown_timer_with_joystick_edit.sv @@
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+------------------------------------
// sample    | sample_valid / sample_ready    | ctje_pkg::sample_t (axis_x, axis_y)
// result    | result_valid / result_ready    | ctje_pkg::result_t (time, cursor, flags)
// config    | cfg_we (no wait, no read-back) | cfg_index, cfg_data
//
// One tick sample per cycle while result_ready does not stall: a transfer lands in
// the input register, and the timer state updates in one pass while it moves on to
// the result register. Result valid rises when the result register loads, and a result
// transfer can be made while result_valid is high.
// Stalls on result_ready hold the result register; the input register keeps
// taking a transfer whenever it is empty or the result register is free or being drained.
// rst (synchronous) clears the timer state and the valid flags; the data registers are not reset.
module countdown_timer_with_joystick_edit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  ctje_pkg::sample_t                sample,
  output logic                             result_valid,
  input  logic                             result_ready,
  output ctje_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic [ctje_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctje_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ctje_pkg::*;

  cfg_t    cfg;
  sample_t held;        // input register
  logic    held_valid;
  logic    out_free;    // result register can load this cycle
  logic    advance;     // held item goes through the timer update
  result_t core_res;

  ctje_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ctje_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .sample  (held),
    .res     (core_res)
  );

  assign out_free     = !result_valid || result_ready;
  assign advance      = held_valid && out_free;
  assign sample_ready = !held_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_ready) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      held <= sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_res;
    end
  end

endmodule
